// File: src/mrl_pkg.sv
// shared constants, codes and types of the memory-type range lookup
package mrl_pkg;

  localparam int MAX_RANGES      = 16;
  localparam int PHYS_ADDR_BITS  = 52;
  localparam int PAGE_INDEX_BITS = 18;

  localparam int REQ_W   = 2;
  localparam int FRAME_W = 40;
  localparam int KIND_W  = 3;
  localparam int PAGE_W  = 18;

  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int MFR_W      = PHYS_ADDR_BITS - 12;
  localparam int START_W    = PHYS_ADDR_BITS;
  localparam int LAST_W     = PHYS_ADDR_BITS + 1;
  localparam int PAGE_USE_W = (PAGE_INDEX_BITS < PAGE_W) ? PAGE_INDEX_BITS : PAGE_W;
  localparam int FIRST_W    = PAGE_USE_W + 21;
  localparam int CMP_W      = (FIRST_W > LAST_W) ? FIRST_W : LAST_W;

  localparam logic [KIND_W-1:0] KIND_UC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WB = 3'd6;

  localparam logic [20:0] PAGE_2M_MASK = 21'h1f_ffff;
  localparam logic [11:0] PAGE_4K_MASK = 12'hfff;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LAST_W-1:0]  last;
    logic [KIND_W-1:0]  kind;
  } range_entry_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    range_entry_t       entry;
  } table_wr_t;

endpackage

// File: src/mrl_range_table.sv
// range table memory, one write port and one registered read port
module mrl_range_table (
  input  logic                       clk_i,
  input  mrl_pkg::table_wr_t         wr_i,
  input  logic [mrl_pkg::IDX_W-1:0]  rd_addr_i,
  output mrl_pkg::range_entry_t      rd_entry_o
);

  mrl_pkg::range_entry_t mem_q [mrl_pkg::MAX_RANGES];
  mrl_pkg::range_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_q;

endmodule

// File: src/mrl_overlap_unit.sv
// shared compare unit: does one stored range overlap the 2 MB page window
module mrl_overlap_unit (
  input  logic [mrl_pkg::CMP_W-1:0] win_first_i,
  input  mrl_pkg::range_entry_t     entry_i,
  output logic                      hit_o
);

  logic [mrl_pkg::CMP_W-1:0] win_last;
  logic [mrl_pkg::CMP_W-1:0] ent_start;
  logic [mrl_pkg::CMP_W-1:0] ent_last;

  assign win_last  = win_first_i | mrl_pkg::CMP_W'(mrl_pkg::PAGE_2M_MASK);
  assign ent_start = mrl_pkg::CMP_W'(entry_i.start);
  assign ent_last  = mrl_pkg::CMP_W'(entry_i.last);
  assign hit_o     = (win_first_i <= ent_last) && (win_last >= ent_start);

endmodule

// File: src/mtrr_range_memory_type_lookup.sv
// top level: memory-type range table with 2 MB page type resolution
//
// input words arrive on the s_axis channel, one request per word; tuser
// carries the request kind (load pair, query page, clear table). every
// request gives exactly one result word on the m_axis channel.
// load, clear, unused and trivial requests (page zero, empty table,
// ignored pairs) produce their result in the cycle they are accepted,
// visible in the cycle after. a storable load first forms the range
// size from the lowest set mask bit, then does the 53-bit add that
// forms the range end and the table write.
// a query walks the stored ranges through one compare unit, one range per
// cycle, fed from the table read port, ending early at an uncacheable hit.
// one request is in flight at a time; tready is high only when the
// sequencer is idle and the result register is empty or being drained.
// a stalled receiver holds the result in the output register and blocks
// new input. reset empties the table (range count zero) and drops any
// pending result; the table storage itself is not cleared.
module mtrr_range_memory_type_lookup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // range_valid, base_frame, range_kind, mask_frame, page_number, zero pad
  input  logic [103:0]  s_axis_tdata_i,
  // req_type
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // stored, table_full, page_kind, is_writeback, zero pad
  output logic [7:0]    m_axis_tdata_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_e;

  logic                          range_valid;
  logic [mrl_pkg::FRAME_W-1:0]   base_frame;
  logic [mrl_pkg::KIND_W-1:0]    range_kind;
  logic [mrl_pkg::FRAME_W-1:0]   mask_frame;
  logic [mrl_pkg::PAGE_W-1:0]    page_number;
  mrl_pkg::req_e                 req_type;

  assign range_valid = s_axis_tdata_i[0];
  assign base_frame  = s_axis_tdata_i[40:1];
  assign range_kind  = s_axis_tdata_i[43:41];
  assign mask_frame  = s_axis_tdata_i[83:44];
  assign page_number = s_axis_tdata_i[101:84];
  assign req_type    = mrl_pkg::req_e'(s_axis_tuser_i);

  state_e                        state_q, state_d;
  logic [mrl_pkg::CNT_W-1:0]     count_q, count_d;
  logic [mrl_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic                          issue_done_q, issue_done_d;
  logic                          ev_v_q, ev_v_d;
  logic                          ev_last_q, ev_last_d;
  logic [mrl_pkg::KIND_W-1:0]    kind_q, kind_d;
  logic [mrl_pkg::START_W-1:0]   base_q, base_d;
  logic [mrl_pkg::START_W-1:0]   szm1_q, szm1_d;
  logic [mrl_pkg::KIND_W-1:0]    lkind_q, lkind_d;
  logic [mrl_pkg::CMP_W-1:0]     qfirst_q, qfirst_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_stored_q, out_stored_d;
  logic                          out_full_q, out_full_d;
  logic [mrl_pkg::KIND_W-1:0]    out_kind_q, out_kind_d;
  logic                          out_wb_q, out_wb_d;

  logic                          accept;
  logic                          out_free;
  logic [mrl_pkg::FRAME_W+11:0]  base_full;
  logic [mrl_pkg::MFR_W-1:0]     mframe;
  logic [mrl_pkg::MFR_W-1:0]     low_ones;
  logic [mrl_pkg::PAGE_USE_W-1:0] page_use;
  logic [mrl_pkg::FIRST_W-1:0]   page_first;
  logic [mrl_pkg::LAST_W-1:0]    load_last;
  logic [mrl_pkg::KIND_W-1:0]    scan_kind;
  logic                          hit;
  mrl_pkg::table_wr_t            tbl_wr;
  mrl_pkg::range_entry_t         rd_entry;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign base_full  = {base_frame, mrl_pkg::PAGE_4K_MASK & 12'h000};
  assign mframe     = mask_frame[mrl_pkg::MFR_W-1:0];
  // ones below the lowest set mask bit
  assign low_ones   = ~mframe & (mframe - mrl_pkg::MFR_W'(1));
  assign page_use   = page_number[mrl_pkg::PAGE_USE_W-1:0];
  assign page_first = {page_use, 21'd0};
  assign load_last  = {1'b0, base_q} + {1'b0, szm1_q};
  assign scan_kind  = hit ? rd_entry.kind : kind_q;

  assign tbl_wr.en          = (state_q == ST_LOAD);
  assign tbl_wr.addr        = count_q[mrl_pkg::IDX_W-1:0];
  assign tbl_wr.entry.start = base_q;
  assign tbl_wr.entry.last  = load_last;
  assign tbl_wr.entry.kind  = lkind_q;

  mrl_range_table u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_addr_i  (idx_q),
    .rd_entry_o (rd_entry)
  );

  mrl_overlap_unit u_overlap (
    .win_first_i (qfirst_q),
    .entry_i     (rd_entry),
    .hit_o       (hit)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    ev_v_d       = 1'b0;
    ev_last_d    = ev_last_q;
    kind_d       = kind_q;
    base_d       = base_q;
    szm1_d       = szm1_q;
    lkind_d      = lkind_q;
    qfirst_d     = qfirst_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_stored_d = out_stored_q;
    out_full_d   = out_full_q;
    out_kind_d   = out_kind_q;
    out_wb_d     = out_wb_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_stored_d = 1'b0;
          out_full_d   = 1'b0;
          out_kind_d   = mrl_pkg::KIND_UC;
          out_wb_d     = 1'b0;
          base_d       = base_full[mrl_pkg::START_W-1:0];
          szm1_d       = {low_ones, mrl_pkg::PAGE_4K_MASK};
          lkind_d      = range_kind;
          qfirst_d     = mrl_pkg::CMP_W'(page_first);
          idx_d        = '0;
          issue_done_d = 1'b0;
          kind_d       = mrl_pkg::KIND_WB;
          case (req_type)
            mrl_pkg::REQ_LOAD: begin
              if (range_valid && (range_kind != mrl_pkg::KIND_WB) && (mframe != '0)) begin
                if (count_q >= mrl_pkg::CNT_W'(mrl_pkg::MAX_RANGES)) begin
                  out_full_d = 1'b1;
                end else begin
                  out_valid_d = 1'b0;
                  state_d     = ST_LOAD;
                end
              end
            end
            mrl_pkg::REQ_QUERY: begin
              if (page_use == '0) begin
                out_kind_d = mrl_pkg::KIND_UC;
              end else if (count_q == '0) begin
                out_kind_d = mrl_pkg::KIND_WB;
                out_wb_d   = 1'b1;
              end else begin
                out_valid_d = 1'b0;
                state_d     = ST_SCAN;
              end
            end
            mrl_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        count_d      = count_q + mrl_pkg::CNT_W'(1);
        out_valid_d  = 1'b1;
        out_stored_d = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        if (!issue_done_q) begin
          ev_v_d    = 1'b1;
          ev_last_d = (mrl_pkg::CNT_W'(idx_q) + mrl_pkg::CNT_W'(1)) == count_q;
          if (ev_last_d) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + mrl_pkg::IDX_W'(1);
          end
        end
        if (ev_v_q) begin
          kind_d = scan_kind;
          // an uncacheable hit settles the page at once
          if ((hit && (rd_entry.kind == mrl_pkg::KIND_UC)) || ev_last_q) begin
            ev_v_d      = 1'b0;
            out_valid_d = 1'b1;
            out_kind_d  = scan_kind;
            out_wb_d    = (scan_kind == mrl_pkg::KIND_WB);
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      ev_v_q       <= 1'b0;
      ev_last_q    <= 1'b0;
      kind_q       <= mrl_pkg::KIND_WB;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      ev_v_q       <= ev_v_d;
      ev_last_q    <= ev_last_d;
      kind_q       <= kind_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    szm1_q       <= szm1_d;
    lkind_q      <= lkind_d;
    qfirst_q     <= qfirst_d;
    out_stored_q <= out_stored_d;
    out_full_q   <= out_full_d;
    out_kind_q   <= out_kind_d;
    out_wb_q     <= out_wb_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_wb_q, out_kind_q, out_full_q, out_stored_q};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mrl_pkg::CNT_W'(mrl_pkg::MAX_RANGES))
    else $error("range count above table depth");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o)
    else $error("ready while a request is in flight");

  a_store_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(out_stored_q && out_full_q))
    else $error("result both stored and dropped");

  a_wb_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_wb_q) |-> (out_kind_q == mrl_pkg::KIND_WB))
    else $error("write-back flag without write-back type");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (state_q == ST_IDLE) && m_axis_tvalid_o && out_stored_q)
    else $error("load did not complete with a stored result");
`endif

endmodule

// File: dv/tb.sv
// self-checking testbench for the memory-type range lookup: directed table, then random sessions
module tb;

  localparam logic [mrl_pkg::KIND_W-1:0] KIND_WC   = 3'd1;
  localparam logic [mrl_pkg::KIND_W-1:0] KIND_RSV2 = 3'd2;
  localparam logic [mrl_pkg::KIND_W-1:0] KIND_RSV3 = 3'd3;
  localparam logic [mrl_pkg::KIND_W-1:0] KIND_WT   = 3'd4;
  localparam logic [mrl_pkg::KIND_W-1:0] KIND_WP   = 3'd5;
  localparam logic [mrl_pkg::KIND_W-1:0] KIND_RSV7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 650;
  localparam int DRAIN_CYCLES     = 40;
  localparam int PRINT_LIMIT      = 100;

  typedef struct packed {
    mrl_pkg::req_e                req;
    logic                         valid;
    logic [mrl_pkg::FRAME_W-1:0]  base;
    logic [mrl_pkg::KIND_W-1:0]   kind;
    logic [mrl_pkg::FRAME_W-1:0]  mask;
    logic [mrl_pkg::PAGE_W-1:0]   page;
  } item_t;

  typedef struct packed {
    logic                        stored;
    logic                        full;
    logic [mrl_pkg::KIND_W-1:0]  kind;
    logic                        wb;
  } res_t;

  typedef struct packed {
    item_t       it;
    int unsigned rep;
    bit          known;
    res_t        want;
  } dir_row_t;

  localparam res_t RES_NONE    = '0;
  localparam res_t RES_WB_PAGE = '{1'b0, 1'b0, mrl_pkg::KIND_WB, 1'b1};
  localparam res_t RES_STORED  = '{1'b1, 1'b0, mrl_pkg::KIND_UC, 1'b0};
  localparam res_t RES_FULL    = '{1'b0, 1'b1, mrl_pkg::KIND_UC, 1'b0};

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  // own copy of the range table
  logic [mrl_pkg::START_W-1:0] tab_start [mrl_pkg::MAX_RANGES];
  logic [mrl_pkg::LAST_W-1:0]  tab_last  [mrl_pkg::MAX_RANGES];
  logic [mrl_pkg::KIND_W-1:0]  tab_kind  [mrl_pkg::MAX_RANGES];
  int                          tab_count = 0;

  res_t due_results [$];

  int errors        = 0;
  int n_words       = 0;
  int n_results     = 0;
  int n_stored      = 0;
  int n_full        = 0;
  int n_query       = 0;
  int n_acted       = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 82;

  always #5 clk_i = ~clk_i;

  mtrr_range_memory_type_lookup u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic res_t lookup_item(item_t it);
    res_t                        r;
    int                          k;
    logic [mrl_pkg::START_W-1:0] base;
    logic [mrl_pkg::LAST_W-1:0]  first;
    logic [mrl_pkg::LAST_W-1:0]  lastp;
    r = '0;
    case (it.req)
      mrl_pkg::REQ_LOAD: begin
        if (it.valid && it.kind != mrl_pkg::KIND_WB && it.mask[mrl_pkg::MFR_W-1:0] != '0) begin
          if (tab_count >= mrl_pkg::MAX_RANGES) begin
            r.full = 1'b1;
          end else begin
            k = 0;
            while (!it.mask[k]) k++;
            base = {it.base, 12'h000};
            tab_start[tab_count] = base;
            tab_last[tab_count]  = {1'b0, base} + ((mrl_pkg::LAST_W'(1) << (k + 12))
                                                   - mrl_pkg::LAST_W'(1));
            tab_kind[tab_count]  = it.kind;
            tab_count++;
            r.stored = 1'b1;
          end
        end
      end
      mrl_pkg::REQ_QUERY: begin
        if (it.page != '0) begin
          first  = mrl_pkg::LAST_W'({it.page, 21'h000000});
          lastp  = first + mrl_pkg::LAST_W'(mrl_pkg::PAGE_2M_MASK);
          r.kind = mrl_pkg::KIND_WB;
          for (int i = 0; i < tab_count; i++) begin
            if (first <= tab_last[i] && lastp >= {1'b0, tab_start[i]}) begin
              r.kind = tab_kind[i];
              if (r.kind == mrl_pkg::KIND_UC) break;
            end
          end
          r.wb = (r.kind == mrl_pkg::KIND_WB);
        end
      end
      mrl_pkg::REQ_CLEAR: begin
        tab_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch %s: got %0d, want %0d (result %0d, t=%0t)",
               field, got, want, n_results, $time);
  endtask

  task automatic check_result(input logic [7:0] word);
    res_t want;
    n_results++;
    if (due_results.size() == 0) begin
      report("unexpected result word", 32'(word), 0);
    end else begin
      want = due_results.pop_front();
      if (word[0] != want.stored) report("stored", 32'(word[0]), 32'(want.stored));
      if (word[1] != want.full) report("table_full", 32'(word[1]), 32'(want.full));
      if (word[4:2] != want.kind) report("page_kind", 32'(word[4:2]), 32'(want.kind));
      if (word[5] != want.wb) report("is_writeback", 32'(word[5]), 32'(want.wb));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
  end

  task automatic send_item(input item_t it, input bit known, input res_t want);
    res_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= it.req;
    s_tdata  <= {2'b00, it.page, it.mask, it.kind, it.base, it.valid};
    do @(posedge clk_i); while (!s_tready);
    r = lookup_item(it);
    due_results.push_back(known ? want : r);
    n_words++;
    if (r.stored) n_stored++;
    if (r.full) n_full++;
    if (it.req == mrl_pkg::REQ_QUERY) n_query++;
    if (it.req != mrl_pkg::REQ_UNUSED && !(it.req == mrl_pkg::REQ_LOAD && !it.valid)) n_acted++;
    // each cycle the sender holds back with the idle chance
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  function automatic item_t make_load();
    item_t       it;
    logic [63:0] rm;
    logic [63:0] rb;
    int          j;
    int          pick;
    rm   = {$urandom, $urandom};
    rb   = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    j    = $urandom_range(0, 30);
    it       = '0;
    it.req   = mrl_pkg::REQ_LOAD;
    it.valid = (pick >= 4);
    it.kind  = rb[42:40];
    it.mask  = (pick < 8) ? '0 : ((rm[39:0] << j) | (40'd1 << j));
    // most ranges sit inside the reachable page space
    it.base  = (pick < 80) ? {13'd0, rb[26:0]} : rb[39:0];
    return it;
  endfunction

  function automatic item_t make_query();
    item_t                      it;
    logic [31:0]                r;
    logic [mrl_pkg::LAST_W-1:0] sh;
    int                         i;
    r       = $urandom;
    it      = '0;
    it.req  = mrl_pkg::REQ_QUERY;
    it.page = r[17:0];
    // aim near the first or last page of a stored range, from one below to two above
    if (tab_count > 0 && r[31:29] < 3'd6) begin
      i  = $urandom_range(0, tab_count - 1);
      sh = r[28] ? (tab_last[i] >> 21) : ({1'b0, tab_start[i]} >> 21);
      if (sh < (mrl_pkg::LAST_W'(1) << mrl_pkg::PAGE_W))
        it.page = sh[mrl_pkg::PAGE_W-1:0] + mrl_pkg::PAGE_W'(r[27:26])
                  - mrl_pkg::PAGE_W'(1);
    end
    if (r[31:29] == 3'd7 && r[25]) it.page = '0;
    return it;
  endfunction

  function automatic item_t make_noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[103:0];
  endfunction

  task automatic run_sessions(input int target);
    item_t clr;
    int    goal;
    int    nl;
    int    nq;
    clr     = '0;
    clr.req = mrl_pkg::REQ_CLEAR;
    goal    = n_acted + target;
    while (n_acted < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        nl = $urandom_range(0, 18);
        nq = $urandom_range(1, 10);
        if ($urandom_range(0, 99) < 70) send_item(clr, 1'b0, RES_NONE);
        repeat (nl) send_item(make_load(), 1'b0, RES_NONE);
        repeat (nq) send_item(make_query(), 1'b0, RES_NONE);
      end else begin
        send_item(make_noise(), 1'b0, RES_NONE);
      end
    end
  endtask

  initial begin
    dir_row_t rows [21];
    rows = '{
      // page zero, then an empty table
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h1},
        1, 1'b1, RES_WB_PAGE},
      '{'{mrl_pkg::REQ_UNUSED, 1'b1, '1, KIND_RSV7, '1, '1}, 1, 1'b1, RES_NONE},
      // ignored pairs: invalid, write-back, zero mask
      '{'{mrl_pkg::REQ_LOAD, 1'b0, 40'h200, mrl_pkg::KIND_UC, '1, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h200, mrl_pkg::KIND_WB, '1, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h200, mrl_pkg::KIND_UC, 40'h0, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h200, mrl_pkg::KIND_UC, 40'hff_ffff_fe00, 18'h0},
        1, 1'b1, RES_STORED},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h0, KIND_WT, 40'hff_ffff_fc00, 18'h0},
        1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h1},
        1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h2},
        1, 1'b0, RES_NONE},
      // widest base, smallest and largest range
      '{'{mrl_pkg::REQ_LOAD, 1'b1, '1, KIND_WP, '1, 18'h0}, 1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h0, KIND_WC, 40'h80_0000_0000, 18'h0},
        1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h3ffff},
        1, 1'b0, RES_NONE},
      // fill the table, then overflow it
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h1000, KIND_RSV2, 40'h1, 18'h0},
        12, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h0, KIND_RSV3, 40'h1, 18'h0},
        1, 1'b1, RES_FULL},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, 40'h0, mrl_pkg::KIND_WB, 40'h1, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h8},
        1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_CLEAR, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h0},
        1, 1'b1, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h1},
        1, 1'b1, RES_WB_PAGE},
      '{'{mrl_pkg::REQ_LOAD, 1'b1, '1, KIND_RSV7, 40'h80_0000_0000, 18'h0},
        1, 1'b0, RES_NONE},
      '{'{mrl_pkg::REQ_QUERY, 1'b0, 40'h0, mrl_pkg::KIND_UC, 40'h0, 18'h2aaaa},
        1, 1'b0, RES_NONE}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      repeat (rows[r].rep) send_item(rows[r].it, rows[r].known, rows[r].want);
    end
    run_sessions(RANDOM_PER_PHASE);
    send_idle_pct = 82;
    recv_idle_pct = 28;
    run_sessions(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_sessions(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words: %0d queries, %0d ranges stored, %0d table-full drops",
             n_words, n_query, n_stored, n_full);
    $display("checked %0d result words, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule
